// ===== design/pfx_pkg.sv =====
package pfx_pkg;

  // Datapath and symbol widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ITER_W = 5;
  localparam int unsigned SYM_W  = 8;

  // ASCII codes the evaluator decodes
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ARITH,
    A_MUL,
    A_NEG_A,
    A_NEG_B,
    A_DIV,
    A_FIX,
    A_DONE
  } alu_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_R,
    S_POP_L,
    S_LOAD_L,
    S_EXEC,
    S_FINISH,
    S_REPORT
  } pfx_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              div_zero;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// ===== design/pfx_stack.sv =====
module pfx_stack #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [pfx_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [pfx_pkg::DATA_W-1:0] rdata_o
);
  import pfx_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pfx_alu.sv =====
module pfx_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfx_pkg::alu_req_t          req_i,
  input  logic [pfx_pkg::DATA_W-1:0] a_i,
  input  logic [pfx_pkg::DATA_W-1:0] b_i,
  output pfx_pkg::alu_rsp_t          rsp_o
);
  import pfx_pkg::*;

  alu_state_e        state_q, state_d;
  alu_op_e           op_q, op_d;
  logic [DATA_W-1:0] acc_q, acc_d;   // product / remainder
  logic [DATA_W-1:0] opa_q, opa_d;   // multiplicand / dividend-quotient
  logic [DATA_W-1:0] opb_q, opb_d;   // multiplier / divisor
  logic [DATA_W-1:0] res_q, res_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              neg_q, neg_d;
  logic              dz_q, dz_d;

  logic [DATA_W:0]   add_x, add_y;
  logic              add_sub;
  logic [DATA_W+1:0] add_sum;
  logic              add_carry;
  logic [DATA_W:0]   rem_sh;
  logic              last_iter;

  assign last_iter = (iter_q == {ITER_W{1'b1}});
  assign rem_sh    = {acc_q, opa_q[DATA_W-1]};

  // the one shared adder
  assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                   + (DATA_W+2)'(add_sub);
  assign add_carry = add_sum[DATA_W+1];

  // adder operand select
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      A_ARITH: begin
        add_x   = {1'b0, opa_q};
        add_y   = {1'b0, opb_q};
        add_sub = (op_q == ALU_SUB);
      end
      A_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = opb_q[0] ? {1'b0, opa_q} : '0;
      end
      A_NEG_A: begin
        add_y   = {1'b0, opa_q};
        add_sub = 1'b1;
      end
      A_NEG_B: begin
        add_y   = {1'b0, opb_q};
        add_sub = 1'b1;
      end
      A_DIV: begin
        add_x   = rem_sh;
        add_y   = {1'b0, opb_q};
        add_sub = 1'b1;
      end
      A_FIX: begin
        add_y   = {1'b0, opa_q};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            ALU_ADD, ALU_SUB: state_d = A_ARITH;
            ALU_MUL:          state_d = A_MUL;
            ALU_DIV:          state_d = (b_i == '0) ? A_DONE : A_NEG_A;
            default:          state_d = A_IDLE;
          endcase
        end
      end
      A_ARITH: state_d = A_DONE;
      A_MUL:   state_d = last_iter ? A_DONE : A_MUL;
      A_NEG_A: state_d = A_NEG_B;
      A_NEG_B: state_d = A_DIV;
      A_DIV:   state_d = last_iter ? A_FIX : A_DIV;
      A_FIX:   state_d = A_DONE;
      A_DONE:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    op_d   = op_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    res_d  = res_q;
    iter_d = iter_q;
    neg_d  = neg_q;
    dz_d   = dz_q;
    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d   = req_i.op;
          opa_d  = a_i;
          opb_d  = b_i;
          acc_d  = '0;
          iter_d = '0;
          neg_d  = a_i[DATA_W-1] ^ b_i[DATA_W-1];
          dz_d   = (req_i.op == ALU_DIV) && (b_i == '0);
          res_d  = '0;
        end
      end
      A_ARITH: res_d = add_sum[DATA_W-1:0];
      A_MUL: begin
        // shift-add, low word only
        acc_d  = add_sum[DATA_W-1:0];
        opa_d  = {opa_q[DATA_W-2:0], 1'b0};
        opb_d  = {1'b0, opb_q[DATA_W-1:1]};
        iter_d = iter_q + 1'b1;
        if (last_iter) begin
          res_d = add_sum[DATA_W-1:0];
        end
      end
      A_NEG_A: begin
        if (opa_q[DATA_W-1]) begin
          opa_d = add_sum[DATA_W-1:0];
        end
      end
      A_NEG_B: begin
        if (opb_q[DATA_W-1]) begin
          opb_d = add_sum[DATA_W-1:0];
        end
        acc_d  = '0;
        iter_d = '0;
      end
      A_DIV: begin
        // restoring step on magnitudes, quotient shifts into opa
        if (add_carry) begin
          acc_d = add_sum[DATA_W-1:0];
          opa_d = {opa_q[DATA_W-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[DATA_W-1:0];
          opa_d = {opa_q[DATA_W-2:0], 1'b0};
        end
        iter_d = iter_q + 1'b1;
      end
      A_FIX:   res_d = neg_q ? add_sum[DATA_W-1:0] : opa_q;
      A_DONE:  res_d = res_q;
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    res_q <= res_d;
    neg_q <= neg_d;
    dz_q  <= dz_d;
  end

  assign rsp_o.done     = (state_q == A_DONE);
  assign rsp_o.div_zero = dz_q;
  assign rsp_o.result   = res_q;

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// Channel | Handshake               | Payload
// --------+-------------------------+------------------------------------------
// input   | in_valid_i/in_ready_o   | symbol_i, last_i
// output  | out_valid_o/out_ready_i | value_o, divide_by_zero_o, stack_overflow_o,
//         |                         | stack_underflow_o
//
// Accepted request to next accept: NUL or digit is decoded and finished; others pop two
// operands, then + - * / run in the ALU (a zero divisor skips the divide); a last request
// adds a report step and any wait for a held result. The shared iterative add/sub unit
// sets the multiply and divide length (one bit per cycle over 32 bits).
// in_ready_o is high only while the sequencer is idle.
// Reset clears the stack count, the sticky flags and the output valid.
// A held result does not block new requests; a later final result waits for it.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pfx_pkg::SYM_W-1:0]         symbol_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [pfx_pkg::DATA_W-1:0] value_o,
  output logic                              divide_by_zero_o,
  output logic                              stack_overflow_o,
  output logic                              stack_underflow_o
);
  import pfx_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  pfx_state_e        state_q, state_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic              last_q, last_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              dz_q, dz_d, ovf_q, ovf_d, unf_q, unf_d;
  logic [DATA_W-1:0] rhs_q, rhs_d;
  logic              rhit_q, rhit_d;   // read data came from the stack
  logic              lhit_q, lhit_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              out_dz_q, out_dz_d, out_ovf_q, out_ovf_d, out_unf_q, out_unf_d;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_a;

  logic              is_digit, is_arith;
  alu_op_e           dec_op;
  logic [CntW-1:0]   count_m1;
  logic [AddrW-1:0]  top_addr, push_addr;
  logic              full, empty;

  assign count_m1  = count_q - CntW'(1);
  assign top_addr  = count_m1[AddrW-1:0];
  assign push_addr = count_q[AddrW-1:0];
  assign full      = (count_q == CntW'(STACK_DEPTH));
  assign empty     = (count_q == '0);

  // symbol decode
  always_comb begin
    is_digit = (sym_q >= SYM_ZERO) && (sym_q <= SYM_NINE);
    is_arith = 1'b1;
    dec_op   = ALU_ADD;
    unique case (sym_q)
      SYM_PLUS:  dec_op = ALU_ADD;
      SYM_MINUS: dec_op = ALU_SUB;
      SYM_STAR:  dec_op = ALU_MUL;
      SYM_SLASH: dec_op = ALU_DIV;
      default:   is_arith = 1'b0;
    endcase
  end

  pfx_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AddrW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign alu_a = lhit_q ? mem_rdata : '0;

  pfx_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (rhs_q),
    .rsp_o  (alu_rsp)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   state_d = in_valid_i ? S_DECODE : S_IDLE;
      S_DECODE: state_d = (sym_q == SYM_NUL || is_digit) ? S_FINISH : S_POP_R;
      S_POP_R:  state_d = S_POP_L;
      S_POP_L:  state_d = S_LOAD_L;
      S_LOAD_L: state_d = is_arith ? S_EXEC : S_FINISH;
      S_EXEC:   state_d = alu_rsp.done ? S_FINISH : S_EXEC;
      S_FINISH: state_d = last_q ? S_REPORT : S_IDLE;
      S_REPORT: state_d = (!out_valid_q || out_ready_i) ? S_IDLE : S_REPORT;
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer outputs and register updates
  always_comb begin
    sym_d       = sym_q;
    last_d      = last_q;
    count_d     = count_q;
    dz_d        = dz_q;
    ovf_d       = ovf_q;
    unf_d       = unf_q;
    rhs_d       = rhs_q;
    rhit_d      = rhit_q;
    lhit_d      = lhit_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    out_dz_d    = out_dz_q;
    out_ovf_d   = out_ovf_q;
    out_unf_d   = out_unf_q;
    mem_we      = 1'b0;
    mem_waddr   = push_addr;
    mem_wdata   = DATA_W'(sym_q - SYM_ZERO);
    mem_re      = 1'b0;
    mem_raddr   = top_addr;
    alu_req     = '{start: 1'b0, op: dec_op};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d  = symbol_i;
          last_d = last_i;
        end
      end
      S_DECODE: begin
        // digit push
        if (is_digit) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      S_POP_R: begin
        rhit_d = !empty;
        if (empty) begin
          unf_d = 1'b1;
        end else begin
          mem_re  = 1'b1;
          count_d = count_m1;
        end
      end
      S_POP_L: begin
        rhs_d  = rhit_q ? mem_rdata : '0;
        lhit_d = !empty;
        if (empty) begin
          unf_d = 1'b1;
        end else begin
          mem_re  = 1'b1;
          count_d = count_m1;
        end
      end
      S_LOAD_L: begin
        alu_req.start = is_arith;
      end
      S_EXEC: begin
        // push the operator result
        if (alu_rsp.done) begin
          dz_d      = dz_q | alu_rsp.div_zero;
          mem_wdata = alu_rsp.result;
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
      end
      S_FINISH: begin
        rhit_d = last_q && !empty;
        mem_re = last_q && !empty;
      end
      S_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = rhit_q ? mem_rdata : '0;
          out_dz_d    = dz_q;
          out_ovf_d   = ovf_q;
          out_unf_d   = unf_q;
          count_d     = '0;
          dz_d        = 1'b0;
          ovf_d       = 1'b0;
          unf_d       = 1'b0;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dz_q        <= 1'b0;
      ovf_q       <= 1'b0;
      unf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dz_q        <= dz_d;
      ovf_q       <= ovf_d;
      unf_q       <= unf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    last_q    <= last_d;
    rhs_q     <= rhs_d;
    rhit_q    <= rhit_d;
    lhit_q    <= lhit_d;
    value_q   <= value_d;
    out_dz_q  <= out_dz_d;
    out_ovf_q <= out_ovf_d;
    out_unf_q <= out_unf_d;
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign value_o           = $signed(value_q);
  assign divide_by_zero_o  = out_dz_q;
  assign stack_overflow_o  = out_ovf_q;
  assign stack_underflow_o = out_unf_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !full)
    else $error("write into full stack");

  a_done_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_EXEC))
    else $error("unit finished outside execute");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPORT && state_d == S_IDLE) |=>
      (count_q == '0 && !dz_q && !ovf_q && !unf_q && out_valid_q))
    else $error("report did not clear stack and flags");

endmodule
